// File: sv/acdfa_pkg.sv
// Shared constants, codes and types for the Aho-Corasick DFA scanner.
`timescale 1ns / 1ps

package acdfa_pkg;

  localparam int NUM_STATES   = 1024;
  localparam int ALPHABET     = 256;
  localparam int MAX_MATCHES  = 8;
  localparam int NUM_PATTERNS = 256;

  localparam int STATE_W = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int SYM_W   = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
  localparam int SLOT_W  = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
  localparam int CNT_W   = $clog2(MAX_MATCHES + 1);
  localparam int PAT_W   = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;

  localparam int TRANS_DEPTH = NUM_STATES * ALPHABET;
  localparam int LIST_DEPTH  = NUM_STATES * (1 << SLOT_W);

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  localparam logic [2:0] ACT_WR_TRANS = 3'd0;
  localparam logic [2:0] ACT_WR_SLOT  = 3'd1;
  localparam logic [2:0] ACT_SET_CNT  = 3'd2;
  localparam logic [2:0] ACT_SET_LEN  = 3'd3;
  localparam logic [2:0] ACT_SCAN     = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRANS,
    ST_COUNT,
    ST_LIST,
    ST_LEN
  } scan_state_t;

endpackage

// File: sv/acdfa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module acdfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/aho_corasick_dfa_scanner.sv
// Top level of the Aho-Corasick DFA scanner: table loads and byte scanning.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------------
//  input   | in        | in_valid/in_stall  | action, state_index, byte_value, ...
//  output  | out       | out_valid/out_stall| match_valid, match_pattern, position,
//          |           |                    | match_total, last_of_run
//
// Load transactions write their table in the accept cycle.
// A scan transaction reads the transition, then the match count; for each
// reported pattern it then reads the match slot, then the pattern length,
// all set by the one read port of each memory in sequence.
// After reset the match-count memory is cleared one entry a cycle; in_stall
// stays high until all 1024 entries are clear. A stalled output holds the walk.
`timescale 1ns / 1ps

module aho_corasick_dfa_scanner
  import acdfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [9:0]  state_index,
  input  logic [7:0]  byte_value,
  input  logic [9:0]  next_state,
  input  logic [2:0]  match_slot,
  input  logic [7:0]  pattern_id,
  input  logic [3:0]  match_count,
  input  logic [7:0]  pattern_length,
  input  logic        text_start,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        match_valid,
  output logic [7:0]  match_pattern,
  output logic [31:0] match_position,
  output logic [31:0] match_total,
  output logic        last_of_run
);

  localparam int TRANS_AW = (TRANS_DEPTH > 1) ? $clog2(TRANS_DEPTH) : 1;
  localparam int LIST_AW  = STATE_W + SLOT_W;

  // Control registers
  scan_state_t        fsm, fsm_next;
  logic [STATE_W-1:0] cur_state;
  logic [31:0]        text_position;
  logic [31:0]        found_total;
  logic [31:0]        scan_pos;
  logic [CNT_W-1:0]   match_n;
  logic [SLOT_W-1:0]  match_k;
  logic [7:0]         cur_id;
  logic               clr_busy;
  logic [STATE_W-1:0] clr_addr;

  // Memory ports
  logic                trans_we, trans_re;
  logic [TRANS_AW-1:0] trans_waddr, trans_raddr;
  logic [STATE_W-1:0]  trans_rdata;
  logic                cnt_we, cnt_re;
  logic [STATE_W-1:0]  cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]    cnt_wdata, cnt_rdata;
  logic                list_we, list_re;
  logic [LIST_AW-1:0]  list_waddr, list_raddr;
  logic [7:0]          list_rdata;
  logic                len_we, len_re;
  logic [PAT_W-1:0]    len_waddr, len_raddr;
  logic [7:0]          len_rdata;

  // Decode of the incoming transaction
  logic               in_acc;
  logic               idx_ok, sym_ok, nxt_ok, slot_ok, pid_ok;
  logic [CNT_W-1:0]   cnt_sat;
  logic               scan_acc, scan_go;
  logic [STATE_W-1:0] eff_state;
  logic [31:0]        pos_now;

  // Walk datapath
  logic [STATE_W-1:0] ns_fixed;
  logic               id_ok;
  logic [7:0]         len_eff;
  logic [32:0]        end1, start_diff;
  logic [31:0]        start_pos;
  logic [31:0]        total_inc;
  logic               out_free;
  logic               emit;
  logic               last_match;
  logic [SLOT_W-1:0]  k_inc;

  assign in_acc = in_valid & ~in_stall;

  assign idx_ok  = 32'(state_index) < NUM_STATES;
  assign sym_ok  = 32'(byte_value) < ALPHABET;
  assign nxt_ok  = 32'(next_state) < NUM_STATES;
  assign slot_ok = 32'(match_slot) < MAX_MATCHES;
  assign pid_ok  = 32'(pattern_id) < NUM_PATTERNS;
  assign cnt_sat = (32'(match_count) > MAX_MATCHES) ? CNT_W'(MAX_MATCHES)
                                                     : CNT_W'(match_count);

  assign scan_acc  = in_acc & (action == ACT_SCAN);
  // Text start clears state and position before this byte is stepped.
  assign eff_state = text_start ? '0 : cur_state;
  assign pos_now   = text_start ? '0 : text_position;
  // A byte outside the alphabet returns to the root without a walk; the position still advances.
  assign scan_go   = scan_acc & sym_ok;

  assign ns_fixed = (32'(trans_rdata) < NUM_STATES) ? trans_rdata : '0;

  assign id_ok      = 32'(cur_id) < NUM_PATTERNS;
  assign len_eff    = id_ok ? len_rdata : 8'd0;
  assign end1       = {1'b0, scan_pos} + 33'd1;
  assign start_diff = end1 - 33'(len_eff);
  assign start_pos  = (33'(len_eff) > end1) ? 32'd0 : start_diff[31:0];
  assign total_inc  = (found_total == SAT32) ? SAT32 : found_total + 32'd1;

  assign k_inc      = match_k + 1'b1;
  assign last_match = (CNT_W'(match_k) + CNT_W'(1)) == match_n;
  assign out_free   = ~out_valid | ~out_stall;

  // Table writes land in the accept cycle; the clearing sweep owns the count port.
  always_comb begin
    trans_we    = in_acc & (action == ACT_WR_TRANS) & idx_ok & sym_ok & nxt_ok;
    trans_waddr = {state_index[STATE_W-1:0], byte_value[SYM_W-1:0]};
    list_we     = in_acc & (action == ACT_WR_SLOT) & idx_ok & slot_ok & pid_ok;
    list_waddr  = {state_index[STATE_W-1:0], match_slot[SLOT_W-1:0]};
    len_we      = in_acc & (action == ACT_SET_LEN) & pid_ok;
    len_waddr   = pattern_id[PAT_W-1:0];
    if (clr_busy) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr;
      cnt_wdata = '0;
    end else begin
      cnt_we    = in_acc & (action == ACT_SET_CNT) & idx_ok;
      cnt_waddr = state_index[STATE_W-1:0];
      cnt_wdata = cnt_sat;
    end
  end

  // Next state of the scan walk
  always_comb begin
    fsm_next = fsm;
    case (fsm)
      ST_IDLE:  if (scan_go) fsm_next = ST_TRANS;
      ST_TRANS: fsm_next = ST_COUNT;
      ST_COUNT: fsm_next = (cnt_rdata == '0) ? ST_IDLE : ST_LIST;
      ST_LIST:  fsm_next = ST_LEN;
      ST_LEN: begin
        if (out_free) begin
          fsm_next = last_match ? ST_IDLE : ST_LIST;
        end
      end
      default:  fsm_next = ST_IDLE;
    endcase
  end

  // Outputs of the scan walk: reads, stall and result load
  always_comb begin
    in_stall    = clr_busy | (fsm != ST_IDLE);
    trans_re    = 1'b0;
    trans_raddr = {eff_state, byte_value[SYM_W-1:0]};
    cnt_re      = 1'b0;
    cnt_raddr   = ns_fixed;
    list_re     = 1'b0;
    list_raddr  = {cur_state, match_k};
    len_re      = 1'b0;
    len_raddr   = list_rdata[PAT_W-1:0];
    emit        = 1'b0;
    case (fsm)
      ST_IDLE:  trans_re = scan_go;
      ST_TRANS: cnt_re = 1'b1;
      ST_COUNT: begin
        list_re    = (cnt_rdata != '0);
        list_raddr = {cur_state, {SLOT_W{1'b0}}};
      end
      ST_LIST:  len_re = 1'b1;
      ST_LEN: begin
        emit       = out_free;
        list_re    = out_free & ~last_match;
        list_raddr = {cur_state, k_inc};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm           <= ST_IDLE;
      cur_state     <= '0;
      text_position <= '0;
      found_total   <= '0;
      match_n       <= '0;
      match_k       <= '0;
      clr_busy      <= 1'b1;
      clr_addr      <= '0;
    end else begin
      fsm <= fsm_next;
      // Sweep the match counts to zero after reset.
      if (clr_busy) begin
        if (32'(clr_addr) == NUM_STATES - 1) begin
          clr_busy <= 1'b0;
        end
        clr_addr <= clr_addr + 1'b1;
      end
      case (fsm)
        ST_IDLE: begin
          if (scan_acc) begin
            scan_pos      <= pos_now;
            text_position <= (pos_now == SAT32) ? SAT32 : pos_now + 32'd1;
            cur_state     <= eff_state;
            if (text_start) begin
              found_total <= '0;
            end
            if (!sym_ok) begin
              cur_state <= '0;
            end
          end
        end
        ST_TRANS: cur_state <= ns_fixed;
        ST_COUNT: begin
          match_n <= cnt_rdata;
          match_k <= '0;
        end
        ST_LIST: cur_id <= list_rdata;
        ST_LEN: begin
          if (emit) begin
            found_total <= total_inc;
            match_k     <= k_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: hold a stalled result, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      match_pattern  <= cur_id;
      match_position <= start_pos;
      match_total    <= total_inc;
      last_of_run    <= last_match;
    end
  end

  assign match_valid = 1'b1;

  acdfa_ram #(.WIDTH(STATE_W), .DEPTH(TRANS_DEPTH)) u_trans_ram (
    .clk   (clk),
    .we    (trans_we),
    .waddr (trans_waddr),
    .wdata (next_state[STATE_W-1:0]),
    .re    (trans_re),
    .raddr (trans_raddr),
    .rdata (trans_rdata)
  );

  acdfa_ram #(.WIDTH(CNT_W), .DEPTH(NUM_STATES)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  acdfa_ram #(.WIDTH(8), .DEPTH(LIST_DEPTH)) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (pattern_id),
    .re    (list_re),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  acdfa_ram #(.WIDTH(8), .DEPTH(NUM_PATTERNS)) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (pattern_length),
    .re    (len_re),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

endmodule
